[design/lpc_pkg.sv]
// Shared types, codes and defaults for the LRU prefetch tag cache.
package lpc_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int ID_BITS_DEF  = 16;

    // request codes
    localparam logic [1:0] REQ_PREFETCH   = 2'd0;
    localparam logic [1:0] REQ_LOOKUP     = 2'd1;
    localparam logic [1:0] REQ_INVALIDATE = 2'd2;
    localparam logic [1:0] REQ_CLEAR      = 2'd3;

    // configuration register indexes
    localparam logic CFG_LIMIT = 1'b0;
    localparam logic CFG_STATS = 1'b1;

    localparam logic [8:0] LIMIT_RESET = 9'd256;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] target_id;
        logic [15:0] message_kind;
    } t_req;

    typedef struct packed {
        logic        was_hit;
        logic        did_evict;
        logic        evict_unused;
        logic [8:0]  removed_count;
        logic [8:0]  occupancy;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] wasted_total;
        logic [31:0] prefetch_total;
    } t_res;

    // counter events, at most one of each per cycle
    typedef struct packed {
        logic hit;
        logic miss;
        logic waste;
        logic pref;
        logic clear;
    } t_stat_ev;

    typedef struct packed {
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] wasted_total;
        logic [31:0] prefetch_total;
    } t_totals;

endpackage

[design/lpc_stats.sv]
// Wrapping statistics counters of the prefetch tag cache.
module lpc_stats (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lpc_pkg::t_stat_ev i_ev,
    output lpc_pkg::t_totals  o_tot
);

    logic [31:0] r_hit;
    logic [31:0] r_miss;
    logic [31:0] r_waste;
    logic [31:0] r_pref;

    // count events, zero on clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ev.clear) begin
            r_hit   <= '0;
            r_miss  <= '0;
            r_waste <= '0;
            r_pref  <= '0;
        end else begin
            if (i_ev.hit)   r_hit   <= r_hit + 32'd1;
            if (i_ev.miss)  r_miss  <= r_miss + 32'd1;
            if (i_ev.waste) r_waste <= r_waste + 32'd1;
            if (i_ev.pref)  r_pref  <= r_pref + 32'd1;
        end
    end

    assign o_tot.hit_total      = r_hit;
    assign o_tot.miss_total     = r_miss;
    assign o_tot.wasted_total   = r_waste;
    assign o_tot.prefetch_total = r_pref;

endmodule

[design/lru_prefetch_tag_cache_core.sv]
// Top level: fully associative LRU prefetch tag cache with a sequential entry scanner.
//
// Usage: drive i_req and raise i_start while o_busy is low; the transaction is
// taken at that edge and o_busy rises. The block walks the entry store one
// slot per cycle through a three-stage read/modify/write scan pipeline and
// then presents one result on o_res, marked by o_done high for exactly one cycle.
// Scan passes by request kind:
//   prefetch hit, lookup miss:          find pass
//   prefetch insert, lookup hit:        find and update passes
//   invalidate:                         mark pass; prefix, compaction if occupied
//   clear statistics:                   no pass
// Each kind ends in the finish step, which also writes an inserted entry; one transaction
// is worked at a time. Counter totals and occupancy in o_res are the values
// after the transaction. Configuration is written through i_cfg_we,
// i_cfg_addr and i_cfg_wdata while idle. Reset empties the cache at once
// through per-slot valid flip-flops (no clearing pass), zeroes the counters
// and loads the limit to 256 with counting enabled. Results cannot be held
// off by the receiver.
module lru_prefetch_tag_cache_core #(
    parameter int CAPACITY = lpc_pkg::CAPACITY_DEF,
    parameter int ID_BITS  = lpc_pkg::ID_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  lpc_pkg::t_req i_req,
    output logic          o_busy,
    output logic          o_done,
    output lpc_pkg::t_res o_res,
    input  logic          i_cfg_we,
    input  logic          i_cfg_addr,
    input  logic [8:0]    i_cfg_wdata
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int KP    = (ID_BITS < 16) ? ID_BITS : 16;
    localparam int KEY_W = 2 * KP;
    localparam int LW    = (CNT_W > 9) ? CNT_W : 9;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FIND = 3'd1;
    localparam logic [2:0] S_UPD  = 3'd2;
    localparam logic [2:0] S_MARK = 3'd3;
    localparam logic [2:0] S_PREF = 3'd4;
    localparam logic [2:0] S_COMP = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             used;
        logic [IDX_W-1:0] rank;
    } t_entry;

    // entry store and invalidate scratch memories
    t_entry           ent_mem [CAPACITY];
    logic             rem_mem [CAPACITY];
    logic [IDX_W-1:0] dec_mem [CAPACITY];

    logic [CAPACITY-1:0] r_valid;

    logic [2:0]       r_state, n_state;
    logic [8:0]       r_cfg_limit;
    logic             r_cfg_stats;
    logic [1:0]       r_req_type;
    logic [KEY_W-1:0] r_key;
    logic             r_st;
    logic [CNT_W-1:0] r_cnt;

    // scan pipeline
    logic [CNT_W-1:0] r_idx;
    logic             r_v1, r_v2, r_val2;
    logic [IDX_W-1:0] r_a1, r_a2;
    t_entry           ent_q, r_e2;
    logic             rem_q;
    logic [IDX_W-1:0] dec_q;
    logic [IDX_W-1:0] rd_addr;

    // search results
    logic             r_fnd, r_lru_fnd, r_free_fnd, r_lru_used;
    logic [IDX_W-1:0] r_f_idx, r_f_rank, r_lru_idx, r_free_idx;
    logic             r_evict, r_ins;
    logic [IDX_W-1:0] r_slot;
    logic [CNT_W-1:0] r_removed;
    logic [IDX_W-1:0] r_prefix;

    // result registers
    logic             r_done, r_o_hit, r_o_ev, r_o_unused;
    logic [CNT_W-1:0] r_o_removed;

    logic             scanning, issue, drained, state_chg;
    logic [CNT_W-1:0] pass_len;
    logic [LW-1:0]    lim_ext, lim, cnt_ext;
    logic             ev_now, ins_now;
    logic [IDX_W-1:0] slot_now, cnt_m1;
    logic             inv_hit;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    t_entry           mem_wd;
    lpc_pkg::t_stat_ev stat_ev;
    lpc_pkg::t_totals  totals;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_limit <= lpc_pkg::LIMIT_RESET;
            r_cfg_stats <= 1'b1;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == lpc_pkg::CFG_LIMIT) r_cfg_limit <= i_cfg_wdata;
            if (i_cfg_addr == lpc_pkg::CFG_STATS) r_cfg_stats <= i_cfg_wdata[0];
        end
    end

    // scan control
    assign scanning  = (r_state != S_IDLE) && (r_state != S_FIN);
    assign pass_len  = (r_state == S_PREF) ? r_cnt : CNT_W'(CAPACITY);
    assign issue     = scanning && (r_idx != pass_len);
    assign drained   = scanning && !issue && !r_v1 && !r_v2;
    assign rd_addr   = issue ? r_idx[IDX_W-1:0] : '0;
    assign state_chg = (n_state != r_state);

    // effective limit and prefetch decision
    assign lim_ext = LW'(r_cfg_limit);
    assign cnt_ext = LW'(r_cnt);
    always_comb begin
        if (lim_ext == '0) begin
            lim = LW'(1);
        end else if (lim_ext > LW'(CAPACITY)) begin
            lim = LW'(CAPACITY);
        end else begin
            lim = lim_ext;
        end
    end
    assign ev_now  = !r_fnd && (cnt_ext >= lim) && (r_cnt != '0) && r_lru_fnd;
    assign ins_now = !r_fnd && (ev_now || r_free_fnd);
    always_comb begin
        if (ev_now && r_free_fnd && (r_free_idx < r_lru_idx)) begin
            slot_now = r_free_idx;
        end else if (ev_now) begin
            slot_now = r_lru_idx;
        end else begin
            slot_now = r_free_idx;
        end
    end
    assign cnt_m1  = IDX_W'(r_cnt - CNT_W'(1));
    assign inv_hit = r_val2 && ((r_key[KP-1:0] == '0) || (r_e2.key[KP-1:0] == r_key[KP-1:0]));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_req.req_type)
                        lpc_pkg::REQ_INVALIDATE: n_state = S_MARK;
                        lpc_pkg::REQ_CLEAR:      n_state = S_FIN;
                        default:                 n_state = S_FIND;
                    endcase
                end
            end
            S_FIND: begin
                if (drained) begin
                    if (r_req_type == lpc_pkg::REQ_PREFETCH) begin
                        n_state = ins_now ? S_UPD : S_FIN;
                    end else begin
                        n_state = r_fnd ? S_UPD : S_FIN;
                    end
                end
            end
            S_UPD:  if (drained) n_state = S_FIN;
            S_MARK: if (drained) n_state = (r_cnt != '0) ? S_PREF : S_FIN;
            S_PREF: if (drained) n_state = S_COMP;
            S_COMP: if (drained) n_state = S_FIN;
            S_FIN:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // memory write port
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_a2;
        mem_wd = r_e2;
        case (r_state)
            S_UPD: begin
                mem_we = r_v2 && r_val2;
                if (r_req_type == lpc_pkg::REQ_PREFETCH) begin
                    mem_wd.rank = r_e2.rank + IDX_W'(1);
                end else if (r_a2 == r_f_idx) begin
                    mem_wd.rank = '0;
                    mem_wd.used = 1'b1;
                end else if (r_e2.rank < r_f_rank) begin
                    mem_wd.rank = r_e2.rank + IDX_W'(1);
                end
            end
            S_COMP: begin
                mem_we      = r_v2 && r_val2;
                mem_wd.rank = r_e2.rank - dec_q;
            end
            S_FIN: begin
                mem_we      = r_ins;
                mem_wa      = r_slot;
                mem_wd.key  = r_key;
                mem_wd.used = 1'b0;
                mem_wd.rank = '0;
            end
            default: ;
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        ent_q <= ent_mem[rd_addr];
        rem_q <= rem_mem[rd_addr];
        dec_q <= dec_mem[ent_q.rank];
        if (mem_we) ent_mem[mem_wa] <= mem_wd;
        if (r_state == S_MARK && r_v2 && r_val2) rem_mem[r_e2.rank] <= inv_hit;
        if (r_state == S_PREF && r_v1) dec_mem[r_a1] <= r_prefix;
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        r_a1   <= r_idx[IDX_W-1:0];
        r_a2   <= r_a1;
        r_e2   <= ent_q;
        r_val2 <= r_valid[r_a1];
    end

    // control, search and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_cnt     <= '0;
            r_idx     <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_done    <= 1'b0;
            r_ins     <= 1'b0;
            r_evict   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= issue;
            r_v2    <= r_v1;
            r_done  <= (r_state == S_FIN);
            if (state_chg) begin
                r_idx <= '0;
            end else if (issue) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_req_type <= i_req.req_type;
                        r_key      <= {i_req.target_id[KP-1:0], i_req.message_kind[KP-1:0]};
                        r_st       <= r_cfg_stats;
                        r_fnd      <= 1'b0;
                        r_lru_fnd  <= 1'b0;
                        r_free_fnd <= 1'b0;
                        r_evict    <= 1'b0;
                        r_ins      <= 1'b0;
                        r_removed  <= '0;
                        r_prefix   <= '0;
                    end
                end
                S_FIND: begin
                    if (r_v2) begin
                        if (r_val2 && r_e2.key == r_key && !r_fnd) begin
                            r_fnd    <= 1'b1;
                            r_f_idx  <= r_a2;
                            r_f_rank <= r_e2.rank;
                        end
                        if (r_val2 && r_e2.rank == cnt_m1) begin
                            r_lru_fnd  <= 1'b1;
                            r_lru_idx  <= r_a2;
                            r_lru_used <= r_e2.used;
                        end
                        if (!r_val2 && !r_free_fnd) begin
                            r_free_fnd <= 1'b1;
                            r_free_idx <= r_a2;
                        end
                    end
                    if (drained && r_req_type == lpc_pkg::REQ_PREFETCH) begin
                        r_evict <= ev_now;
                        r_ins   <= ins_now;
                        r_slot  <= slot_now;
                        if (ev_now) r_valid[r_lru_idx] <= 1'b0;
                    end
                end
                S_MARK: begin
                    if (r_v2 && inv_hit) begin
                        r_valid[r_a2] <= 1'b0;
                        r_removed     <= r_removed + CNT_W'(1);
                    end
                end
                S_PREF: begin
                    if (r_v1) r_prefix <= r_prefix + IDX_W'(rem_q);
                end
                S_FIN: begin
                    r_o_hit     <= r_fnd && (r_req_type == lpc_pkg::REQ_PREFETCH ||
                                             r_req_type == lpc_pkg::REQ_LOOKUP);
                    r_o_ev      <= r_evict;
                    r_o_unused  <= r_evict && !r_lru_used;
                    r_o_removed <= r_removed;
                    if (r_ins) begin
                        r_valid[r_slot] <= 1'b1;
                        r_cnt <= r_cnt - CNT_W'(r_evict) + CNT_W'(1);
                    end else if (r_req_type == lpc_pkg::REQ_INVALIDATE) begin
                        r_cnt <= r_cnt - r_removed;
                    end
                end
                default: ;
            endcase
        end
    end

    // statistics events
    always_comb begin
        stat_ev       = '0;
        stat_ev.waste = (r_state == S_MARK) && r_v2 && inv_hit && !r_e2.used && r_st;
        if (r_state == S_FIN) begin
            stat_ev.clear = (r_req_type == lpc_pkg::REQ_CLEAR);
            stat_ev.waste = r_evict && !r_lru_used;
            stat_ev.pref  = r_ins && r_st;
            stat_ev.hit   = (r_req_type == lpc_pkg::REQ_LOOKUP) && r_fnd && r_st;
            stat_ev.miss  = (r_req_type == lpc_pkg::REQ_LOOKUP) && !r_fnd && r_st;
        end
    end

    lpc_stats u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ev    (stat_ev),
        .o_tot   (totals)
    );

    // result ports
    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res.was_hit        = r_o_hit;
    assign o_res.did_evict      = r_o_ev;
    assign o_res.evict_unused   = r_o_unused;
    assign o_res.removed_count  = 9'(r_o_removed);
    assign o_res.occupancy      = 9'(r_cnt);
    assign o_res.hit_total      = totals.hit_total;
    assign o_res.miss_total     = totals.miss_total;
    assign o_res.wasted_total   = totals.wasted_total;
    assign o_res.prefetch_total = totals.prefetch_total;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_ext <= LW'(CAPACITY))
        else $error("occupancy above capacity");
    a_done_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_FIN))
        else $error("result strobe without finish step");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted transaction did not raise busy");
    a_evict_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.did_evict) |-> !o_res.was_hit)
        else $error("eviction reported together with hit");
`endif

endmodule

[test/lru_prefetch_tag_cache_core_test.sv]
// Self-checking testbench for the LRU prefetch tag cache core.
module lru_prefetch_tag_cache_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = 256;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 800;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    lpc_pkg::t_req i_req = '0;
    logic o_busy;
    logic o_done;
    lpc_pkg::t_res o_res;
    logic i_cfg_we = 1'b0;
    logic i_cfg_addr = 1'b0;
    logic [8:0] i_cfg_wdata = '0;

    lru_prefetch_tag_cache_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_req(i_req),
        .o_busy(o_busy), .o_done(o_done), .o_res(o_res),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // cache shadow state
    logic        tag_valid [CAP];
    logic [31:0] tag_key   [CAP];
    logic        tag_used  [CAP];
    int          tag_age   [CAP];
    int          tag_count;
    logic [31:0] hits, misses, wasted, prefetches;
    logic [8:0]  limit_reg;
    logic        stats_on;

    lpc_pkg::t_req pending_reqs[$];
    lpc_pkg::t_res expected_res[$];
    int   send_idle_pct;
    int   mismatches;
    int   idle_cycles;
    logic timed_out;

    function automatic void drop_slot(int s);
        int r;
        r = tag_age[s];
        tag_valid[s] = 1'b0;
        for (int i = 0; i < CAP; i++)
            if (tag_valid[i] && tag_age[i] > r) tag_age[i]--;
        tag_count--;
    endfunction

    function automatic int find_slot(logic [31:0] key);
        for (int i = 0; i < CAP; i++)
            if (tag_valid[i] && tag_key[i] == key) return i;
        return -1;
    endfunction

    // compute the result of one request and advance the shadow cache
    function automatic lpc_pkg::t_res cache_predict(lpc_pkg::t_req rq);
        lpc_pkg::t_res r;
        logic [31:0] key;
        int lim, s, lru, r0, removed;
        r = '0;
        key = {rq.target_id, rq.message_kind};
        lim = int'(limit_reg);
        if (lim == 0) lim = 1;
        if (lim > CAP) lim = CAP;
        removed = 0;
        case (rq.req_type)
            lpc_pkg::REQ_PREFETCH: begin
                if (find_slot(key) >= 0) begin
                    r.was_hit = 1'b1;
                end else begin
                    if (tag_count >= lim && tag_count > 0) begin
                        lru = -1;
                        for (int i = 0; i < CAP; i++)
                            if (lru < 0 && tag_valid[i] && tag_age[i] == tag_count - 1) lru = i;
                        if (lru >= 0) begin
                            r.did_evict = 1'b1;
                            if (!tag_used[lru]) begin
                                r.evict_unused = 1'b1;
                                wasted++;
                            end
                            drop_slot(lru);
                        end
                    end
                    s = -1;
                    for (int i = 0; i < CAP; i++)
                        if (s < 0 && !tag_valid[i]) s = i;
                    if (s >= 0) begin
                        for (int i = 0; i < CAP; i++)
                            if (tag_valid[i]) tag_age[i]++;
                        tag_valid[s] = 1'b1;
                        tag_key[s] = key;
                        tag_used[s] = 1'b0;
                        tag_age[s] = 0;
                        tag_count++;
                        if (stats_on) prefetches++;
                    end
                end
            end
            lpc_pkg::REQ_LOOKUP: begin
                s = find_slot(key);
                if (s >= 0) begin
                    r.was_hit = 1'b1;
                    tag_used[s] = 1'b1;
                    r0 = tag_age[s];
                    for (int i = 0; i < CAP; i++)
                        if (tag_valid[i] && tag_age[i] < r0) tag_age[i]++;
                    tag_age[s] = 0;
                    if (stats_on) hits++;
                end else if (stats_on) begin
                    misses++;
                end
            end
            lpc_pkg::REQ_INVALIDATE: begin
                for (int i = 0; i < CAP; i++)
                    if (tag_valid[i] && (rq.message_kind == 16'd0 ||
                            tag_key[i][15:0] == rq.message_kind)) begin
                        if (!tag_used[i] && stats_on) wasted++;
                        drop_slot(i);
                        removed++;
                    end
            end
            default: begin
                hits = '0;
                misses = '0;
                wasted = '0;
                prefetches = '0;
            end
        endcase
        r.removed_count = removed[8:0];
        r.occupancy = tag_count[8:0];
        r.hit_total = hits;
        r.miss_total = misses;
        r.wasted_total = wasted;
        r.prefetch_total = prefetches;
        return r;
    endfunction

    // issue requests from the pending queue at the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n && !o_busy && !i_start && pending_reqs.size() > 0 &&
                $urandom_range(99) >= send_idle_pct) begin
            i_req <= pending_reqs[0];
            i_start <= 1'b1;
        end else if (i_start && !o_busy) begin
            i_start <= 1'b1;
        end else begin
            i_start <= 1'b0;
        end
    end

    // predict on accept, check results on strobe, run the watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_start && !o_busy) || o_done) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (i_start && !o_busy) begin
                expected_res.push_back(cache_predict(i_req));
                void'(pending_reqs.pop_front());
            end
            if (o_done) begin
                if (expected_res.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %p", o_res);
                end else begin
                    if (o_res !== expected_res[0]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", expected_res[0], o_res);
                    end
                    void'(expected_res.pop_front());
                end
            end
            if (idle_cycles > WATCHDOG_LIMIT) timed_out <= 1'b1;
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || expected_res.size() > 0 || i_start)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [8:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == lpc_pkg::CFG_LIMIT) limit_reg = value;
        else stats_on = value[0];
    endtask

    function automatic lpc_pkg::t_req make_req(logic [1:0] op, logic [15:0] tgt,
                                               logic [15:0] kind);
        lpc_pkg::t_req q;
        q.req_type = op;
        q.target_id = tgt;
        q.message_kind = kind;
        return q;
    endfunction

    // mostly small key space for hits, sometimes full-width noise
    function automatic lpc_pkg::t_req random_req();
        logic [1:0] op;
        logic [15:0] tgt, kind;
        int p;
        p = $urandom_range(99);
        if (p < 50) op = lpc_pkg::REQ_PREFETCH;
        else if (p < 88) op = lpc_pkg::REQ_LOOKUP;
        else if (p < 97) op = lpc_pkg::REQ_INVALIDATE;
        else op = lpc_pkg::REQ_CLEAR;
        if ($urandom_range(9) == 0) begin
            tgt = 16'($urandom);
            kind = 16'($urandom);
        end else begin
            tgt = 16'($urandom_range(7));
            kind = 16'($urandom_range(4));
            if ($urandom_range(3) == 0) tgt = ~tgt;
        end
        return make_req(op, tgt, kind);
    endfunction

    task automatic run_phase(int n, int idle_pct);
        send_idle_pct = idle_pct;
        for (int i = 0; i < n; i++) pending_reqs.push_back(random_req());
        wait_drained();
    endtask

    initial begin
        for (int i = 0; i < CAP; i++) begin
            tag_valid[i] = 1'b0;
            tag_key[i] = '0;
            tag_used[i] = 1'b0;
            tag_age[i] = 0;
        end
        tag_count = 0;
        hits = '0; misses = '0; wasted = '0; prefetches = '0;
        limit_reg = lpc_pkg::LIMIT_RESET;
        stats_on = 1'b1;
        send_idle_pct = 0;
        mismatches = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every request kind, limit extremes
        pending_reqs.push_back(make_req(lpc_pkg::REQ_LOOKUP, 16'hFFFF, 16'hFFFF));
        pending_reqs.push_back(make_req(lpc_pkg::REQ_PREFETCH, 16'hFFFF, 16'hFFFF));
        pending_reqs.push_back(make_req(lpc_pkg::REQ_PREFETCH, 16'hFFFF, 16'hFFFF));
        pending_reqs.push_back(make_req(lpc_pkg::REQ_PREFETCH, 16'h0000, 16'h0000));
        pending_reqs.push_back(make_req(lpc_pkg::REQ_PREFETCH, 16'h5555, 16'hAAAA));
        pending_reqs.push_back(make_req(lpc_pkg::REQ_LOOKUP, 16'h0000, 16'h0000));
        pending_reqs.push_back(make_req(lpc_pkg::REQ_INVALIDATE, 16'h0000, 16'hAAAA));
        pending_reqs.push_back(make_req(lpc_pkg::REQ_INVALIDATE, 16'h1234, 16'h0000));
        pending_reqs.push_back(make_req(lpc_pkg::REQ_CLEAR, 16'hFFFF, 16'hFFFF));
        wait_drained();
        // limit of zero acts as one; eviction of used and unused entries
        write_reg(lpc_pkg::CFG_LIMIT, 9'd0);
        pending_reqs.push_back(make_req(lpc_pkg::REQ_PREFETCH, 16'd1, 16'd1));
        pending_reqs.push_back(make_req(lpc_pkg::REQ_LOOKUP, 16'd1, 16'd1));
        pending_reqs.push_back(make_req(lpc_pkg::REQ_PREFETCH, 16'd2, 16'd1));
        pending_reqs.push_back(make_req(lpc_pkg::REQ_PREFETCH, 16'd3, 16'd1));
        wait_drained();
        // limit above capacity; then lowered below occupancy
        write_reg(lpc_pkg::CFG_LIMIT, 9'h1FF);
        for (int i = 0; i < 6; i++)
            pending_reqs.push_back(make_req(lpc_pkg::REQ_PREFETCH, 16'(i), 16'd2));
        wait_drained();
        write_reg(lpc_pkg::CFG_LIMIT, 9'd2);
        write_reg(lpc_pkg::CFG_STATS, 9'd0);
        pending_reqs.push_back(make_req(lpc_pkg::REQ_PREFETCH, 16'd9, 16'd2));
        pending_reqs.push_back(make_req(lpc_pkg::REQ_LOOKUP, 16'd9, 16'd2));
        pending_reqs.push_back(make_req(lpc_pkg::REQ_LOOKUP, 16'd9, 16'd7));
        pending_reqs.push_back(make_req(lpc_pkg::REQ_INVALIDATE, 16'd0, 16'd2));
        wait_drained();

        // random phases across settings and idle rates
        write_reg(lpc_pkg::CFG_STATS, 9'd1);
        write_reg(lpc_pkg::CFG_LIMIT, 9'd8);
        run_phase(250, 0);
        write_reg(lpc_pkg::CFG_LIMIT, 9'd1);
        run_phase(150, 88);
        write_reg(lpc_pkg::CFG_LIMIT, 9'd256);
        write_reg(lpc_pkg::CFG_STATS, 9'd0);
        run_phase(200, 15);
        write_reg(lpc_pkg::CFG_STATS, 9'd1);
        write_reg(lpc_pkg::CFG_LIMIT, 9'd20);
        run_phase(250, 0);
        write_reg(lpc_pkg::CFG_LIMIT, 9'd3);
        run_phase(150, 15);

        if (mismatches == 0 && !timed_out)
            $display("lru_prefetch_tag_cache_core verification clean");
        else
            $display("lru_prefetch_tag_cache_core verification failed");
        $finish;
    end

    // end the run when nothing moves for too long
    initial begin
        wait (timed_out);
        $display("lru_prefetch_tag_cache_core verification failed");
        $finish;
    end
endmodule

[sim.f]
design/lpc_pkg.sv
design/lpc_stats.sv
design/lru_prefetch_tag_cache_core.sv
test/lru_prefetch_tag_cache_core_test.sv
